### sv/seven_segment_serial_display_driver_assert.svh
// ---------------------------------------------------------------------------
// seven segment serial display driver: assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SSD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### sv/ssd_pkg.sv
// ---------------------------------------------------------------------------
// ssd_pkg
// shared types, constants and segment encoding for the display driver
// ---------------------------------------------------------------------------
package ssd_pkg;

   // digits on the display
   localparam int NUM_DIGITS = 4;

   localparam int VALUE_W   = 14;
   localparam int BRIGHT_W  = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_EN = 1'b1;

   function automatic int pow10(input int n);
      int r;
      r = 1;
      for (int i = 0; i < n; i++) r = r * 10;
      return r;
   endfunction

   localparam int MAX_VALUE = pow10(NUM_DIGITS) - 1;

   // bytes per sequence: command, address, digits, control
   localparam int LAST_IDX     = 2 + NUM_DIGITS;
   localparam int BYTE_IDX_W   = $clog2(LAST_IDX + 1);
   localparam int DIGIT_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int CONV_W       = $clog2(NUM_DIGITS + 1);

   // divide by ten via reciprocal, exact for values below 2**14
   localparam int DIV10_SHIFT = 16;
   localparam int DIV10_RECIP = (1 << DIV10_SHIFT) / 10 + 1;
   localparam int DIV10_PROD_W = VALUE_W + DIV10_SHIFT;

   localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
   localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
   localparam logic [7:0] CMD_DISP_CTRL  = 8'h80;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_ST_CLK   = 5'd1,
      PH_ST_DHI   = 5'd2,
      PH_ST_DLO   = 5'd3,
      PH_BIT_LO   = 5'd4,
      PH_BIT_DATA = 5'd5,
      PH_BIT_HI   = 5'd6,
      PH_ACK_LO   = 5'd7,
      PH_ACK_WAIT = 5'd8,
      PH_ACK_END  = 5'd9,
      PH_SP_CLO   = 5'd10,
      PH_SP_DLO   = 5'd11,
      PH_SP_CHI   = 5'd12,
      PH_SP_DHI   = 5'd13
   } phase_type;

   typedef struct packed {
      logic clk_out;
      logic dio_out;
      logic dio_release;
      logic busy_res;
      logic done_res;
   } pins_type;

   // segment pattern of one decimal digit, blank for other codes
   function automatic logic [7:0] seg_encode(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h3F;
         4'd1: s = 8'h06;
         4'd2: s = 8'h5B;
         4'd3: s = 8'h4F;
         4'd4: s = 8'h66;
         4'd5: s = 8'h6D;
         4'd6: s = 8'h7C;
         4'd7: s = 8'h07;
         4'd8: s = 8'h7F;
         4'd9: s = 8'h67;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

### sv/seven_segment_serial_display_driver.sv
// ---------------------------------------------------------------------------
// seven_segment_serial_display_driver
// two-wire segment display driver, one waveform phase step per input beat
// ---------------------------------------------------------------------------
// usage:
//   every req beat is one phase tick of the clock/data waveform. a beat with
//   command set, while the driver is idle, loads a value (clamped to the
//   largest number the digits can show) and starts a sequence of three
//   frames: data command, address plus digit bytes, display control.
//   every req beat gives exactly one rsp beat carrying the pin levels
//   (clk_out, dio_out, dio_release) plus busy and done flags.
//   dio_in is sampled in the acknowledge wait; the driver holds its pins
//   for as long as dio_in stays high.
// timing:
//   the rsp beat is registered from the req beat; one beat per cycle sustained, set
//   by the single phase register update. the output register is refilled in
//   the cycle it drains, so req_tready only drops while rsp is stalled.
// reset:
//   synchronous, active high: idle, clock and data levels high, brightness 1,
//   display on, no rsp beat pending.
// csr port:
//   csr_wr_en writes csr_wdata to register csr_index (0 brightness,
//   1 display enable), intended only while the driver is idle
// ---------------------------------------------------------------------------
`include "seven_segment_serial_display_driver_assert.svh"

module seven_segment_serial_display_driver (
   input  logic                              clock,
   input  logic                              reset,
   // req tdata: command [0], value [14:1], dio_in [15]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ssd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp tdata: clk_out [0], dio_out [1], dio_release [2], busy_res [3],
   // done_res [4], zero [7:5]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [ssd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssd_pkg::*;

   // input fields
   logic               req_command;
   logic [VALUE_W-1:0] req_value;
   logic               req_dio_in;
   logic               req_accept;

   // configuration registers
   logic [BRIGHT_W-1:0] brightness_ff;
   logic                display_en_ff;

   // sequencer state
   phase_type            phase_ff, phase_in;
   logic [BYTE_IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [3:0]           bit_cnt_ff, bit_cnt_in;
   logic [7:0]           shift_ff, shift_in;
   logic                 clk_level_ff, clk_level_in;
   logic                 dio_level_ff, dio_level_in;

   // digit conversion: one digit per beat after a load, least significant first
   logic [VALUE_W-1:0]   work_ff, work_in;
   logic [CONV_W-1:0]    conv_left_ff, conv_left_in;
   logic [3:0]           digit_ff [NUM_DIGITS];
   logic                 digit_push;
   logic [DIV10_PROD_W-1:0] div_prod;
   logic [VALUE_W-1:0]   div_quot;
   logic [VALUE_W-1:0]   div_rem;
   logic [VALUE_W-1:0]   load_value;

   // byte selection
   logic [BYTE_IDX_W-1:0] sel_idx;
   logic [BYTE_IDX_W-1:0] sel_digit;
   logic [7:0]           sel_byte;

   // result register
   logic     rsp_valid_ff;
   pins_type rsp_pins_ff;
   pins_type pins_in;
   logic     released;
   logic     done;

   assign req_command = req_tdata[0];
   assign req_value   = req_tdata[VALUE_W:1];
   assign req_dio_in  = req_tdata[VALUE_W+1];

   // output register empties in the same cycle it refills
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_pins_ff.done_res, rsp_pins_ff.busy_res,
                        rsp_pins_ff.dio_release, rsp_pins_ff.dio_out,
                        rsp_pins_ff.clk_out};

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHT_W'(1);
         display_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BRIGHTNESS: brightness_ff <= csr_wdata[BRIGHT_W-1:0];
            CSR_DISPLAY_EN: display_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---- divide by ten for the digit split ----
   assign div_prod = DIV10_PROD_W'(work_ff) * DIV10_PROD_W'(DIV10_RECIP);
   assign div_quot = VALUE_W'(div_prod >> DIV10_SHIFT);
   assign div_rem  = work_ff - ((div_quot << 3) + (div_quot << 1));

   // clamp to what the digits can show
   assign load_value = (int'(req_value) > MAX_VALUE) ? VALUE_W'(MAX_VALUE) : req_value;

   assign digit_push = req_accept && (conv_left_ff != '0);

   // digit store is a shift line: after all pushes entry 0 holds the leading digit
   always_ff @(posedge clock) begin
      if (digit_push) begin
         digit_ff[0] <= div_rem[3:0];
         for (int i = 1; i < NUM_DIGITS; i++) digit_ff[i] <= digit_ff[i-1];
      end
   end

   // ---- byte to send next: current index at start, following one after ack ----
   assign sel_idx   = (phase_ff == PH_ACK_END) ? byte_idx_ff + BYTE_IDX_W'(1) : byte_idx_ff;
   assign sel_digit = sel_idx - BYTE_IDX_W'(2);

   always_comb begin
      if (sel_idx == BYTE_IDX_W'(0)) begin
         sel_byte = CMD_DATA_WRITE;
      end else if (sel_idx == BYTE_IDX_W'(1)) begin
         sel_byte = CMD_ADDR_BASE;
      end else if (sel_idx < BYTE_IDX_W'(LAST_IDX)) begin
         sel_byte = seg_encode(digit_ff[sel_digit[DIGIT_IDX_W-1:0]]);
      end else begin
         sel_byte = CMD_DISP_CTRL | {4'b0000, display_en_ff, brightness_ff};
      end
   end

   // ---- next state ----
   always_comb begin
      phase_in     = phase_ff;
      byte_idx_in  = byte_idx_ff;
      bit_cnt_in   = bit_cnt_ff;
      shift_in     = shift_ff;
      clk_level_in = clk_level_ff;
      dio_level_in = dio_level_ff;
      work_in      = work_ff;
      conv_left_in = conv_left_ff;
      if (req_accept) begin
         if (conv_left_ff != '0) begin
            work_in      = div_quot;
            conv_left_in = conv_left_ff - CONV_W'(1);
         end
         case (phase_ff)
            PH_IDLE: begin
               if (req_command) begin
                  work_in      = load_value;
                  conv_left_in = CONV_W'(NUM_DIGITS);
                  byte_idx_in  = '0;
                  phase_in     = PH_ST_CLK;
               end
            end
            PH_ST_CLK: begin
               clk_level_in = 1'b1;
               phase_in     = PH_ST_DHI;
            end
            PH_ST_DHI: begin
               dio_level_in = 1'b1;
               phase_in     = PH_ST_DLO;
            end
            PH_ST_DLO: begin
               dio_level_in = 1'b0;
               shift_in     = sel_byte;
               bit_cnt_in   = '0;
               phase_in     = PH_BIT_LO;
            end
            PH_BIT_LO: begin
               clk_level_in = 1'b0;
               phase_in     = PH_BIT_DATA;
            end
            PH_BIT_DATA: begin
               dio_level_in = shift_ff[0];
               phase_in     = PH_BIT_HI;
            end
            PH_BIT_HI: begin
               clk_level_in = 1'b1;
               shift_in     = shift_ff >> 1;
               bit_cnt_in   = bit_cnt_ff + 4'd1;
               phase_in     = (bit_cnt_ff == 4'd7) ? PH_ACK_LO : PH_BIT_LO;
            end
            PH_ACK_LO: begin
               clk_level_in = 1'b0;
               phase_in     = PH_ACK_WAIT;
            end
            PH_ACK_WAIT: begin
               // hold until the display pulls data low
               if (!req_dio_in) begin
                  clk_level_in = 1'b1;
                  phase_in     = PH_ACK_END;
               end
            end
            PH_ACK_END: begin
               clk_level_in = 1'b0;
               // command byte, last digit and control byte close their frame
               if (byte_idx_ff == '0 || byte_idx_ff >= BYTE_IDX_W'(LAST_IDX - 1)) begin
                  phase_in = PH_SP_CLO;
               end else begin
                  byte_idx_in = sel_idx;
                  shift_in    = sel_byte;
                  bit_cnt_in  = '0;
                  phase_in    = PH_BIT_LO;
               end
            end
            PH_SP_CLO: begin
               clk_level_in = 1'b0;
               phase_in     = PH_SP_DLO;
            end
            PH_SP_DLO: begin
               dio_level_in = 1'b0;
               phase_in     = PH_SP_CHI;
            end
            PH_SP_CHI: begin
               clk_level_in = 1'b1;
               phase_in     = PH_SP_DHI;
            end
            PH_SP_DHI: begin
               dio_level_in = 1'b1;
               if (byte_idx_ff >= BYTE_IDX_W'(LAST_IDX)) begin
                  phase_in = PH_IDLE;
               end else begin
                  byte_idx_in = byte_idx_ff + BYTE_IDX_W'(1);
                  phase_in    = PH_ST_CLK;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // ---- result fields ----
   always_comb begin
      released = (phase_ff == PH_ACK_LO) || (phase_ff == PH_ACK_WAIT) ||
                 (phase_ff == PH_ACK_END);
      done     = (phase_ff == PH_SP_DHI) && (byte_idx_ff >= BYTE_IDX_W'(LAST_IDX));
      pins_in.clk_out     = clk_level_in;
      pins_in.dio_out     = released ? 1'b0 : dio_level_in;
      pins_in.dio_release = released;
      pins_in.busy_res    = (phase_in != PH_IDLE);
      pins_in.done_res    = done;
   end

   // ---- state registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         byte_idx_ff  <= '0;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         clk_level_ff <= 1'b1;
         dio_level_ff <= 1'b1;
         conv_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         byte_idx_ff  <= byte_idx_in;
         bit_cnt_ff   <= bit_cnt_in;
         shift_ff     <= shift_in;
         clk_level_ff <= clk_level_in;
         dio_level_ff <= dio_level_in;
         conv_left_ff <= conv_left_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (req_accept) begin
         rsp_pins_ff <= pins_in;
      end
   end

   // ---- assertions ----
   `SSD_ASSERT_NEXT(a_load_starts, clock, reset,
      req_accept && req_command && phase_ff == PH_IDLE,
      phase_ff == PH_ST_CLK && rsp_tvalid && rsp_tdata[3], "load did not start a sequence")
   `SSD_ASSERT_SAME(a_digits_ready, clock, reset,
      phase_ff == PH_BIT_LO && byte_idx_ff >= BYTE_IDX_W'(2),
      conv_left_ff == '0, "digit split not finished before a digit byte")
   `SSD_ASSERT_SAME(a_ack_clock_low, clock, reset,
      phase_ff == PH_ACK_WAIT, !clk_level_ff, "clock not low while waiting for ack")
   `SSD_ASSERT_SAME(a_idle_lines_high, clock, reset,
      phase_ff == PH_IDLE, clk_level_ff && dio_level_ff, "lines not high while idle")

endmodule
